@@ sv/cia_pkg.sv @@
// ----------------------------------------------------------------------------
// cia_pkg: shared types and constants of the clamped integer accumulator
// Mode codes, beat layout, controller states and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package cia_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FIELD_W        = 32;
	localparam int MODE_W         = 3;
	localparam int STATUS_W       = 2;
	localparam int CFG_INDEX_W    = 1;
	localparam int IN_TDATA_W     = 40;
	localparam int OUT_TDATA_W    = 40;

	// Input beat: mode [2:0], operand [34:3]
	localparam int MODE_LSB    = 0;
	localparam int OPERAND_LSB = MODE_LSB + MODE_W;
	// Output beat: new_value [31:0], clamp_status [33:32]
	localparam int VALUE_LSB   = 0;
	localparam int STATUS_LSB  = VALUE_LSB + FIELD_W;

	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD = 3'd0,
		MODE_ADD  = 3'd1,
		MODE_SUB  = 3'd2,
		MODE_MUL  = 3'd3,
		MODE_DIV  = 3'd4,
		MODE_MOD  = 3'd5
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		CLAMP_NONE  = 2'd0,
		CLAMP_UPPER = 2'd1,
		CLAMP_LOWER = 2'd2
	} clamp_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_LOWER = 1'b0,
		REG_UPPER = 1'b1
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_FIX,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic div_step;
		logic div_fix;
		logic commit;
	} cia_cmd_t;

	typedef struct packed {
		logic div_op;
		logic div_last;
		logic out_free;
	} cia_stat_t;

endpackage

@@ sv/cia_datapath.sv @@
// ----------------------------------------------------------------------------
// cia_datapath: accumulator, bounds, exact-result unit and output register
// Forms the exact result at double width (load, add, subtract, combinational
// multiply or a restoring divider of one quotient bit per cycle), clamps it
// to the bounds and holds the result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module cia_datapath #(
	parameter int DATA_WIDTH = cia_pkg::DATA_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cia_pkg::cia_cmd_t             cmd,
	output cia_pkg::cia_stat_t            stat,
	input  logic [cia_pkg::IN_TDATA_W-1:0]  in_data,
	input  logic                          cfg_we,
	input  logic [cia_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [cia_pkg::FIELD_W-1:0]     cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [cia_pkg::OUT_TDATA_W-1:0] out_data
);
	import cia_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int XW = 2 * DATA_WIDTH;
	localparam int CW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

	logic signed [W-1:0]  acc_q;
	logic signed [W-1:0]  lo_q;
	logic signed [W-1:0]  hi_q;
	logic [MODE_W-1:0]    mode_q;
	logic signed [W-1:0]  op_q;
	logic signed [XW-1:0] exact_q;
	logic                 byp_q;
	logic [STATUS_W-1:0]  byp_st_q;
	logic [W-1:0]         dq_q;
	logic [W-1:0]         rem_q;
	logic [W-1:0]         dvs_q;
	logic [CW-1:0]        cnt_q;
	logic                 qneg_q;
	logic                 rneg_q;
	logic                 out_valid_q;
	logic signed [FIELD_W-1:0] out_value_q;
	logic [STATUS_W-1:0]  out_status_q;

	logic signed [XW-1:0] acc_x;
	logic signed [XW-1:0] op_x;
	logic signed [XW-1:0] exact_d;
	logic                 byp_d;
	logic [STATUS_W-1:0]  byp_st_d;
	logic                 op_zero;
	logic [W-1:0]         acc_mag;
	logic [W-1:0]         op_mag;
	logic [W:0]           trial;
	logic                 trial_ge;
	logic signed [XW-1:0] quo_x;
	logic signed [XW-1:0] rem_x;
	logic signed [XW-1:0] lo_x;
	logic signed [XW-1:0] hi_x;
	logic signed [W-1:0]  res;
	logic [STATUS_W-1:0]  res_st;

	assign acc_x   = XW'(acc_q);
	assign op_x    = XW'(op_q);
	assign op_zero = (op_q == '0);
	assign acc_mag = acc_q[W-1] ? W'(-acc_q) : W'(acc_q);
	assign op_mag  = op_q[W-1] ? W'(-op_q) : W'(op_q);

	assign stat.div_op   = ((mode_q == MODE_DIV) || (mode_q == MODE_MOD)) && !op_zero;
	assign stat.div_last = (cnt_q == '0);
	assign stat.out_free = !out_valid_q || out_ready;

	// Exact result of the operations outside the divider, plus the forced outcomes
	always_comb begin
		exact_d  = acc_x;
		byp_d    = 1'b0;
		byp_st_d = CLAMP_NONE;
		case (mode_q)
			MODE_LOAD: exact_d = op_x;
			MODE_ADD:  exact_d = acc_x + op_x;
			MODE_SUB:  exact_d = acc_x - op_x;
			MODE_MUL:  exact_d = acc_q * op_q;
			MODE_DIV: begin
				if (op_zero) begin
					if (acc_q > 0) begin
						exact_d  = XW'(hi_q);
						byp_d    = 1'b1;
						byp_st_d = CLAMP_UPPER;
					end else if (acc_q < 0) begin
						exact_d  = XW'(lo_q);
						byp_d    = 1'b1;
						byp_st_d = CLAMP_LOWER;
					end else begin
						exact_d = '0;
					end
				end
			end
			MODE_MOD:  exact_d = acc_x;
			default: begin
				// unused modes keep the accumulator untouched
				byp_d = 1'b1;
			end
		endcase
	end

	assign trial    = {rem_q, dq_q[W-1]};
	assign trial_ge = (trial >= {1'b0, dvs_q});
	assign quo_x    = qneg_q ? -$signed(XW'(dq_q)) : $signed(XW'(dq_q));
	assign rem_x    = rneg_q ? -$signed(XW'(rem_q)) : $signed(XW'(rem_q));

	// Lower bound is checked first; with crossed bounds, results at or above it take the upper bound
	assign lo_x = XW'(lo_q);
	assign hi_x = XW'(hi_q);
	always_comb begin
		if (byp_q) begin
			res    = W'(exact_q);
			res_st = byp_st_q;
		end else if (exact_q < lo_x) begin
			res    = lo_q;
			res_st = CLAMP_LOWER;
		end else if (exact_q > hi_x) begin
			res    = hi_q;
			res_st = CLAMP_UPPER;
		end else begin
			res    = W'(exact_q);
			res_st = CLAMP_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			lo_q        <= {1'b1, {(W-1){1'b0}}};
			hi_q        <= {1'b0, {(W-1){1'b1}}};
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_LOWER)
					lo_q <= cfg_data[W-1:0];
				else
					hi_q <= cfg_data[W-1:0];
			end
			if (cmd.exec)
				cnt_q <= CW'(W - 1);
			else if (cmd.div_step)
				cnt_q <= cnt_q - 1'b1;
			if (cmd.commit) begin
				acc_q       <= res;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= in_data[MODE_LSB +: MODE_W];
			op_q   <= in_data[OPERAND_LSB +: W];
		end
		if (cmd.exec) begin
			exact_q  <= exact_d;
			byp_q    <= byp_d;
			byp_st_q <= byp_st_d;
			dq_q     <= acc_mag;
			rem_q    <= '0;
			dvs_q    <= op_mag;
			qneg_q   <= acc_q[W-1] ^ op_q[W-1];
			rneg_q   <= acc_q[W-1];
		end
		if (cmd.div_step) begin
			rem_q <= trial_ge ? W'(trial - {1'b0, dvs_q}) : trial[W-1:0];
			dq_q  <= {dq_q[W-2:0], trial_ge};
		end
		if (cmd.div_fix) begin
			exact_q <= (mode_q == MODE_DIV) ? quo_x : rem_x;
			byp_q   <= 1'b0;
		end
		if (cmd.commit) begin
			out_value_q  <= FIELD_W'(res);
			out_status_q <= res_st;
		end
	end

	assign out_valid = out_valid_q;
	always_comb begin
		out_data = '0;
		out_data[VALUE_LSB +: FIELD_W]   = out_value_q;
		out_data[STATUS_LSB +: STATUS_W] = out_status_q;
	end

endmodule

@@ sv/cia_ctrl.sv @@
// ----------------------------------------------------------------------------
// cia_ctrl: sequencing state machine of the clamped integer accumulator
// Takes one beat, runs the direct or the divider path and commits the
// clamped result once the output register is free.
// ----------------------------------------------------------------------------
module cia_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output cia_pkg::cia_cmd_t  cmd,
	input  cia_pkg::cia_stat_t stat
);
	import cia_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = stat.div_op ? ST_DIV : ST_DONE;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last)
					state_d = ST_FIX;
			end
			ST_FIX: begin
				cmd.div_fix = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				// hold the result until the output register can take it
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

@@ sv/clamped_integer_accumulator_unit.sv @@
// ----------------------------------------------------------------------------
// clamped_integer_accumulator_unit: signed accumulator clamped to bounds
// Applies load, add, subtract, multiply, divide or modulo to one accumulator
// and clamps the exact result to the configured lower and upper bounds.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one beat per operation (mode, operand). m_* channel: one
//   beat per operation (new_value, clamp_status). cfg_* channel: writes the
//   lower bound (index 0) or upper bound (index 1); always ready, to be used
//   only while no operation is in flight.
//   Load, add, subtract and multiply pass from acceptance through the execute
//   and done states into the output register. Divide and modulo by a non-zero
//   operand also pass through the divide and fix-up states: the restoring
//   divider yields one quotient bit per cycle. A new beat is accepted the
//   cycle after the previous result is committed, so one operation is in
//   flight at a time.
//   Reset clears the accumulator, opens the bounds to the full signed range
//   and empties the output register.
//   While the receiver stalls the result beat holds in the output register;
//   one further beat is accepted and computed, then waits for that register.
// ----------------------------------------------------------------------------
module clamped_integer_accumulator_unit #(
	parameter int DATA_WIDTH = cia_pkg::DATA_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [cia_pkg::IN_TDATA_W-1:0]  s_tdata,  // mode[2:0], operand[34:3]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [cia_pkg::OUT_TDATA_W-1:0] m_tdata,  // new_value[31:0], clamp_status[33:32]
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cia_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [cia_pkg::FIELD_W-1:0]     cfg_data
);
	import cia_pkg::*;

	cia_cmd_t  cmd;
	cia_stat_t stat;

	assign cfg_ready = 1'b1;

	cia_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	cia_datapath #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (s_tdata),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

@@ sv/cia_checker.sv @@
// ----------------------------------------------------------------------------
// cia_checker: port-level checks of the clamped integer accumulator
// Watches the stream ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module cia_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [cia_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import cia_pkg::*;

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// Reserved clamp code never appears
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[STATUS_LSB +: STATUS_W] != 2'd3))
		else $error("clamp status out of range");

	// One operation at a time: no beat taken straight after another
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an operation is in flight");

	// A result cannot appear before its beat has passed the execute state
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result appeared too early");

	// Output empty once reset has been seen
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result valid during reset");

endmodule

bind clamped_integer_accumulator_unit cia_checker u_cia_checker (.*);

@@ sim/cia_result_checker.sv @@
// ----------------------------------------------------------------------------
// cia_result_checker: result predictor and scoreboard for the accumulator
// Watches the operation, result and register-write channels, keeps its own
// copy of the bounds and the accumulator, and compares every result beat
// field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module cia_result_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [cia_pkg::IN_TDATA_W-1:0]  s_tdata,  // mode[2:0], operand[34:3]
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [cia_pkg::OUT_TDATA_W-1:0] m_tdata,  // new_value[31:0], clamp_status[33:32]
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [cia_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [cia_pkg::FIELD_W-1:0]     cfg_data,
	output int                              mismatches,
	output int                              outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import cia_pkg::*;

	typedef struct {
		logic signed [FIELD_W-1:0] value;
		clamp_t                    status;
	} acc_result_t;

	acc_result_t               predicted_results[$];
	logic signed [FIELD_W-1:0] acc_model;
	logic signed [FIELD_W-1:0] lower_model;
	logic signed [FIELD_W-1:0] upper_model;
	int                        result_count;

	// Exact result at double width, then clamp: lower bound checked first.
	function automatic acc_result_t next_accumulator(
		input logic [MODE_W-1:0]       md,
		input logic signed [FIELD_W-1:0] opd,
		input logic signed [FIELD_W-1:0] cur_v,
		input logic signed [FIELD_W-1:0] lo_v,
		input logic signed [FIELD_W-1:0] hi_v
	);
		acc_result_t r;
		longint      cur;
		longint      op;
		longint      lo;
		longint      hi;
		longint      exact;
		bit          apply;
		cur = cur_v;
		op = opd;
		lo = lo_v;
		hi = hi_v;
		exact = cur;
		apply = 1'b1;
		r.value = cur_v;
		r.status = CLAMP_NONE;
		case (md)
			MODE_LOAD: exact = op;
			MODE_ADD:  exact = cur + op;
			MODE_SUB:  exact = cur - op;
			MODE_MUL:  exact = cur * op;
			MODE_DIV: begin
				if (op != 0) begin
					exact = cur / op;
				end else if (cur > 0) begin
					r.value = hi_v;
					r.status = CLAMP_UPPER;
					apply = 1'b0;
				end else if (cur < 0) begin
					r.value = lo_v;
					r.status = CLAMP_LOWER;
					apply = 1'b0;
				end else begin
					exact = 0;
				end
			end
			MODE_MOD:  exact = (op == 0) ? cur : cur % op;
			default:   apply = 1'b0;
		endcase
		if (apply) begin
			if (exact < lo) begin
				r.value = lo_v;
				r.status = CLAMP_LOWER;
			end else if (exact > hi) begin
				r.value = hi_v;
				r.status = CLAMP_UPPER;
			end else begin
				r.value = exact[FIELD_W-1:0];
				r.status = CLAMP_NONE;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		acc_result_t             want;
		logic signed [FIELD_W-1:0] got_value;
		logic [STATUS_W-1:0]     got_status;
		int                      errors;
		if (!arst_n) begin
			predicted_results.delete();
			acc_model <= '0;
			lower_model <= {1'b1, {(FIELD_W-1){1'b0}}};
			upper_model <= {1'b0, {(FIELD_W-1){1'b1}}};
			mismatches <= 0;
			outstanding <= 0;
			result_count <= 0;
		end else begin
			errors = 0;
			// Retire the oldest prediction before queuing a new one.
			if (m_tvalid && m_tready) begin
				got_value = m_tdata[VALUE_LSB +: FIELD_W];
				got_status = m_tdata[STATUS_LSB +: STATUS_W];
				result_count <= result_count + 1;
				if (predicted_results.size() == 0) begin
					$display("%0t: result beat %0d with none predicted, got value %0d status %0d",
						$time, result_count, got_value, got_status);
					errors++;
				end else begin
					want = predicted_results.pop_front();
					if (got_value !== want.value) begin
						$display("%0t: result %0d value differs, expected %0d got %0d",
							$time, result_count, want.value, got_value);
						errors++;
					end
					if (got_status !== want.status) begin
						$display("%0t: result %0d status differs, expected %0d got %0d",
							$time, result_count, want.status, got_status);
						errors++;
					end
				end
			end
			mismatches <= mismatches + errors;
			if (s_tvalid && s_tready) begin
				want = next_accumulator(s_tdata[MODE_LSB +: MODE_W],
					s_tdata[OPERAND_LSB +: FIELD_W], acc_model, lower_model, upper_model);
				predicted_results.push_back(want);
				acc_model <= want.value;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_LOWER)
					lower_model <= cfg_data;
				else
					upper_model <= cfg_data;
			end
			outstanding <= predicted_results.size();
		end
	end

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb: top level for the clamped integer accumulator
// Drives a directed set of edge cases, then random operations under a run of
// bound settings (wide, narrow, non-negative, crossed, pinned at either end),
// with random gaps on both sides and one stretch without any.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cia_pkg::*;

	localparam logic [MODE_W-1:0] MODE_SPARE_A   = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_B   = 3'd7;
	localparam int                WATCHDOG_LIMIT = 4000;
	localparam int                PHASE_ITEMS    = 175;
	localparam logic [FIELD_W-1:0] S_MIN         = 32'h8000_0000;
	localparam logic [FIELD_W-1:0] S_MAX         = 32'h7fff_ffff;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_LOWER;
	logic [FIELD_W-1:0]     cfg_data = '0;
	int                     mismatches;
	int                     outstanding;
	int                     quiet_cycles = 0;
	bit                     steady = 1'b0;
	logic [FIELD_W-1:0]     bound_lo = S_MIN;
	logic [FIELD_W-1:0]     bound_hi = S_MAX;

	always #6 clk = ~clk;

	clamped_integer_accumulator_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	cia_result_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 36);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
			|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Leave tvalid high across back-to-back beats; lower it only for a gap.
	task automatic send_op(input logic [MODE_W-1:0] md, input logic [FIELD_W-1:0] opd);
		logic [IN_TDATA_W-1:0] beat;
		beat = '0;
		beat[MODE_LSB +: MODE_W] = md;
		beat[OPERAND_LSB +: FIELD_W] = opd;
		if (!steady && $urandom_range(99) < 36) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 36);
		end
		s_tdata <= beat;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	// Hold off until every predicted result has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [FIELD_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_bounds(input logic [FIELD_W-1:0] lo, input logic [FIELD_W-1:0] hi);
		drain();
		write_reg(REG_LOWER, lo);
		write_reg(REG_UPPER, hi);
		bound_lo = lo;
		bound_hi = hi;
	endtask

	function automatic logic [FIELD_W-1:0] pick_operand();
		logic [FIELD_W-1:0] v;
		case ($urandom_range(9))
			0:       v = '0;
			1, 2, 3: v = $urandom_range(40) - 20;
			4: begin
				case ($urandom_range(3))
					0:       v = S_MIN;
					1:       v = S_MAX;
					2:       v = '1;
					default: v = 32'd1;
				endcase
			end
			5:       v = ($urandom_range(1) ? bound_lo : bound_hi) + $urandom_range(6) - 3;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic run_random(input int n);
		int                  r;
		logic [MODE_W-1:0]   md;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 20)      md = MODE_LOAD;
			else if (r < 40) md = MODE_ADD;
			else if (r < 60) md = MODE_SUB;
			else if (r < 72) md = MODE_MUL;
			else if (r < 84) md = MODE_DIV;
			else if (r < 96) md = MODE_MOD;
			else             md = $urandom_range(1) ? MODE_SPARE_B : MODE_SPARE_A;
			send_op(md, pick_operand());
		end
	endtask

	initial begin
		logic [FIELD_W-1:0] ra;
		logic [FIELD_W-1:0] rb;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Edge cases under the reset bounds.
		send_op(MODE_LOAD, S_MAX);
		send_op(MODE_ADD, 32'd1);
		send_op(MODE_DIV, 32'd0);
		send_op(MODE_LOAD, S_MIN);
		send_op(MODE_SUB, 32'd1);
		send_op(MODE_MUL, '1);
		send_op(MODE_LOAD, S_MIN);
		send_op(MODE_DIV, '1);
		send_op(MODE_LOAD, -32'sd7);
		send_op(MODE_DIV, 32'd2);
		send_op(MODE_LOAD, -32'sd7);
		send_op(MODE_MOD, 32'd3);
		send_op(MODE_DIV, 32'd0);
		send_op(MODE_LOAD, 32'd0);
		send_op(MODE_DIV, 32'd0);
		send_op(MODE_MOD, 32'd0);
		send_op(MODE_LOAD, 32'd7);
		send_op(MODE_MOD, -32'sd3);
		send_op(MODE_LOAD, 32'd123456);
		send_op(MODE_MUL, 32'd65536);
		send_op(MODE_LOAD, -32'sd100000);
		send_op(MODE_MUL, 32'd100000);
		send_op(MODE_SPARE_A, '1);
		send_op(MODE_LOAD, 32'd100);
		send_op(MODE_SUB, S_MIN);
		send_op(MODE_SPARE_B, '0);
		send_op(MODE_ADD, S_MIN);

		set_bounds(S_MIN, S_MAX);
		run_random(PHASE_ITEMS);
		set_bounds(-32'sd1000, 32'd1000);
		run_random(PHASE_ITEMS);
		set_bounds(32'd0, 32'd65535);
		run_random(PHASE_ITEMS);
		// Crossed bounds: a modulo by zero after this re-clamps the held value.
		set_bounds(32'd100, -32'sd100);
		run_random(PHASE_ITEMS);
		set_bounds(S_MAX, S_MAX);
		run_random(PHASE_ITEMS);
		set_bounds(S_MIN, S_MIN);
		run_random(PHASE_ITEMS);
		ra = $urandom;
		rb = $urandom;
		set_bounds(ra, rb);
		run_random(PHASE_ITEMS);
		set_bounds(S_MIN, S_MAX);
		steady = 1'b1;
		run_random(PHASE_ITEMS);
		steady = 1'b0;

		drain();
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
